// File: rtl/ecal_pkg.sv
// Shared constants, calendar table and BCD helper for the epoch-to-calendar converter.
package ecal_pkg;

	// Exact reciprocals: floor(x * RECIP >> SHIFT) equals floor(x / divisor) over each input range.
	// Seconds to minutes: (t >> 2) / 15, shift 34.
	localparam logic [30:0] RECIP_15   = 31'd1145324613;
	// Seconds to hours: (t >> 4) / 225, shift 36.
	localparam logic [28:0] RECIP_225  = 29'd305419897;
	// Seconds to days: (t >> 7) / 675, shift 35.
	localparam logic [25:0] RECIP_675  = 26'd50903317;
	// Days to four-year groups: days / 1461, shift 26.
	localparam logic [15:0] RECIP_1461 = 16'd45934;
	// Weekday: (days + bias) / 7, shift 19.
	localparam logic [16:0] RECIP_7    = 17'd74899;

	// Days in one four-year group.
	localparam logic [10:0] GROUP_DAYS = 11'd1461;

	// Group 25 starts in year 2100, which the clock cannot show.
	localparam logic [5:0] FIRST_BAD_GROUP = 6'd25;

	// Weekday of day zero (2000-01-01 was a Saturday).
	localparam logic [2:0] WEEKDAY_BIAS = 3'd6;

	// Cumulative day at the start of each month, per year slot of a group (slot 0 is leap).
	localparam logic [10:0] CUM_DAYS [4][12] = '{
		'{11'd0,    11'd31,   11'd60,   11'd91,   11'd121,  11'd152,
		  11'd182,  11'd213,  11'd244,  11'd274,  11'd305,  11'd335},
		'{11'd366,  11'd397,  11'd425,  11'd456,  11'd486,  11'd517,
		  11'd547,  11'd578,  11'd609,  11'd639,  11'd670,  11'd700},
		'{11'd731,  11'd762,  11'd790,  11'd821,  11'd851,  11'd882,
		  11'd912,  11'd943,  11'd974,  11'd1004, 11'd1035, 11'd1065},
		'{11'd1096, 11'd1127, 11'd1155, 11'd1186, 11'd1216, 11'd1247,
		  11'd1277, 11'd1308, 11'd1339, 11'd1369, 11'd1400, 11'd1430}
	};

	// Two-digit BCD of a value 0..99; the tens digit comes from a multiply by 103/1024.
	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [13:0] p;
		logic [3:0]  tens;
		logic [3:0]  ones;
		p    = 14'(v) * 14'd103;
		tens = p[13:10];
		ones = 4'(v - 7'(tens) * 7'd10);
		return {tens, ones};
	endfunction

endpackage

// File: rtl/ecal_if.sv
// Channel interfaces for the timestamp input and the calendar result.
interface ecal_stamp_if;
	logic        valid;
	logic        ready;
	logic [31:0] seconds_since_2000;

	modport source (output valid, output seconds_since_2000, input ready);
	modport sink (input valid, input seconds_since_2000, output ready);
endinterface

interface ecal_cal_if;
	logic       valid;
	logic       ready;
	logic [6:0] second_bcd;
	logic [6:0] minute_bcd;
	logic [5:0] hour_bcd;
	logic [2:0] weekday_bcd;
	logic [5:0] date_bcd;
	logic [4:0] month_bcd;
	logic [7:0] year_bcd;
	logic       out_of_range;

	modport source (
		output valid, output second_bcd, output minute_bcd, output hour_bcd,
		output weekday_bcd, output date_bcd, output month_bcd, output year_bcd,
		output out_of_range, input ready
	);
	modport sink (
		input valid, input second_bcd, input minute_bcd, input hour_bcd,
		input weekday_bcd, input date_bcd, input month_bcd, input year_bcd,
		input out_of_range, output ready
	);
endinterface

// File: rtl/epoch_to_bcd_calendar_core.sv
// Top level: converts seconds since 2000-01-01 into BCD clock register fields.
//
// Each timestamp transaction produces exactly one calendar transaction, and a new timestamp can
// be taken in every cycle unless the output stalls, so the sustained rate is one per cycle.
// The five stages hold together: when the result waits for ready, every stage stops and the
// input ready drops in the same cycle. The longest path is in the first stage, where three
// parallel constant-reciprocal multiplies (at most 30 by 31 bits) split the seconds into
// minute, hour and day counts. Dates after 2099-12-31 23:59:59 set out_of_range and zero
// every other field. There is no configuration and no state besides the pipeline.
module epoch_to_bcd_calendar_core (
	input logic       clk,
	input logic       arst_n,
	ecal_stamp_if.sink  stamp,
	ecal_cal_if.source  cal
);

	// Pipeline advance: the whole pipeline moves unless the output holds an untaken result.
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	assign en          = !v_s5 || cal.ready;
	assign stamp.ready = en;
	assign cal.valid   = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= stamp.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage 1: minute, hour and day counts by exact reciprocal multiplies.
	logic [60:0] prod_min;
	logic [56:0] prod_hr;
	logic [50:0] prod_day;
	logic [5:0]  t_s1;
	logic [5:0]  q_min_s1;
	logic [5:0]  q_hr_s1;
	logic [15:0] days_s1;

	assign prod_min = 61'(stamp.seconds_since_2000[31:2]) * 61'(ecal_pkg::RECIP_15);
	assign prod_hr  = 57'(stamp.seconds_since_2000[31:4]) * 57'(ecal_pkg::RECIP_225);
	assign prod_day = 51'(stamp.seconds_since_2000[31:7]) * 51'(ecal_pkg::RECIP_675);

	// Only the low bits of the seconds, minutes and hours counts feed the remainders.
	always_ff @(posedge clk) begin
		if (en) begin
			t_s1     <= stamp.seconds_since_2000[5:0];
			q_min_s1 <= prod_min[39:34];
			q_hr_s1  <= prod_hr[41:36];
			days_s1  <= prod_day[50:35];
		end
	end

	// Stage 2: time-of-day remainders, four-year group and weekday quotient.
	logic [5:0]  sec_d;
	logic [5:0]  min_d;
	logic [4:0]  hr_d;
	logic [31:0] prod_grp;
	logic [16:0] wk_sum;
	logic [33:0] prod_wk;
	logic [5:0]  sec_s2;
	logic [5:0]  min_s2;
	logic [4:0]  hr_s2;
	logic [10:0] days_s2;
	logic [5:0]  grp_s2;
	logic [2:0]  q_wk_s2;

	assign sec_d    = t_s1 - q_min_s1 * 6'd60;
	assign min_d    = q_min_s1 - q_hr_s1 * 6'd60;
	assign hr_d     = q_hr_s1[4:0] - days_s1[4:0] * 5'd24;
	assign prod_grp = 32'(days_s1) * 32'(ecal_pkg::RECIP_1461);
	assign wk_sum   = 17'(days_s1) + 17'(ecal_pkg::WEEKDAY_BIAS);
	assign prod_wk  = 34'(wk_sum) * 34'(ecal_pkg::RECIP_7);

	always_ff @(posedge clk) begin
		if (en) begin
			sec_s2  <= sec_d;
			min_s2  <= min_d;
			hr_s2   <= hr_d;
			days_s2 <= days_s1[10:0];
			grp_s2  <= prod_grp[31:26];
			q_wk_s2 <= prod_wk[21:19];
		end
	end

	// Stage 3: day within the group, year slot, weekday and time BCD.
	logic [10:0] rem_d;
	logic [1:0]  slot_d;
	logic [2:0]  wd_d;
	logic [6:0]  sec_bcd_s3;
	logic [6:0]  min_bcd_s3;
	logic [5:0]  hr_bcd_s3;
	logic [10:0] rem_s3;
	logic [1:0]  slot_s3;
	logic [2:0]  wd_s3;
	logic [5:0]  grp_s3;
	logic        oor_s3;

	assign rem_d = days_s2 - 11'(grp_s2) * ecal_pkg::GROUP_DAYS;
	assign wd_d  = (days_s2[2:0] + ecal_pkg::WEEKDAY_BIAS) - q_wk_s2 * 3'd7;

	always_comb begin
		if (rem_d >= ecal_pkg::CUM_DAYS[3][0]) begin
			slot_d = 2'd3;
		end else if (rem_d >= ecal_pkg::CUM_DAYS[2][0]) begin
			slot_d = 2'd2;
		end else if (rem_d >= ecal_pkg::CUM_DAYS[1][0]) begin
			slot_d = 2'd1;
		end else begin
			slot_d = 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sec_bcd_s3 <= 7'(ecal_pkg::to_bcd(7'(sec_s2)));
			min_bcd_s3 <= 7'(ecal_pkg::to_bcd(7'(min_s2)));
			hr_bcd_s3  <= 6'(ecal_pkg::to_bcd(7'(hr_s2)));
			rem_s3     <= rem_d;
			slot_s3    <= slot_d;
			wd_s3      <= wd_d;
			grp_s3     <= grp_s2;
			oor_s3     <= grp_s2 >= ecal_pkg::FIRST_BAD_GROUP;
		end
	end

	// Stage 4: month by table compares in the slot's row, day of month and year BCD.
	logic [3:0]  mon_d;
	logic [4:0]  day_d;
	logic [6:0]  year_d;
	logic [6:0]  sec_bcd_s4;
	logic [6:0]  min_bcd_s4;
	logic [5:0]  hr_bcd_s4;
	logic [2:0]  wd_s4;
	logic        oor_s4;
	logic [3:0]  mon_s4;
	logic [4:0]  day_s4;
	logic [7:0]  year_bcd_s4;

	// The row is increasing, so the last start not above the day picks the month.
	always_comb begin
		mon_d = '0;
		for (int i = 1; i < 12; i++) begin
			if (rem_s3 >= ecal_pkg::CUM_DAYS[slot_s3][i]) begin
				mon_d = 4'(i);
			end
		end
	end

	assign day_d  = 5'(rem_s3 - ecal_pkg::CUM_DAYS[slot_s3][mon_d] + 11'd1);
	assign year_d = {grp_s3[4:0], slot_s3};

	always_ff @(posedge clk) begin
		if (en) begin
			sec_bcd_s4  <= sec_bcd_s3;
			min_bcd_s4  <= min_bcd_s3;
			hr_bcd_s4   <= hr_bcd_s3;
			wd_s4       <= wd_s3;
			oor_s4      <= oor_s3;
			mon_s4      <= mon_d;
			day_s4      <= day_d;
			year_bcd_s4 <= ecal_pkg::to_bcd(year_d);
		end
	end

	// Stage 5: output register; an out-of-range date clears every field but the flag.
	always_ff @(posedge clk) begin
		if (en) begin
			cal.out_of_range <= oor_s4;
			if (oor_s4) begin
				cal.second_bcd  <= '0;
				cal.minute_bcd  <= '0;
				cal.hour_bcd    <= '0;
				cal.weekday_bcd <= '0;
				cal.date_bcd    <= '0;
				cal.month_bcd   <= '0;
				cal.year_bcd    <= '0;
			end else begin
				cal.second_bcd  <= sec_bcd_s4;
				cal.minute_bcd  <= min_bcd_s4;
				cal.hour_bcd    <= hr_bcd_s4;
				cal.weekday_bcd <= wd_s4;
				cal.date_bcd    <= 6'(ecal_pkg::to_bcd(7'(day_s4)));
				cal.month_bcd   <= 5'(ecal_pkg::to_bcd(7'(mon_s4) + 7'd1));
				cal.year_bcd    <= year_bcd_s4;
			end
		end
	end

endmodule

// File: rtl/ecal_checker.sv
// Port-level checks of the epoch-to-calendar converter, bound to its top level.
module ecal_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] second_bcd,
	input logic [6:0] minute_bcd,
	input logic [5:0] hour_bcd,
	input logic [2:0] weekday_bcd,
	input logic [5:0] date_bcd,
	input logic [4:0] month_bcd,
	input logic [7:0] year_bcd,
	input logic       out_of_range
);

	// A stalled result stays offered with the same seconds, date, year and range flag.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(second_bcd) && $stable(date_bcd)
			&& $stable(year_bcd) && $stable(out_of_range))
		else $error("stalled calendar transaction changed");

	// The input is ready exactly when the output stage can move.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stage");

	// An out-of-range result carries only the flag.
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> second_bcd == '0 && minute_bcd == '0 && hour_bcd == '0
			&& weekday_bcd == '0 && date_bcd == '0 && month_bcd == '0 && year_bcd == '0)
		else $error("out-of-range result has nonzero fields");

	// A valid date has a nonzero day and month, decimal digits and a weekday below seven.
	a_date_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_of_range |-> date_bcd != '0 && date_bcd[3:0] <= 4'd9
			&& month_bcd != '0 && month_bcd[3:0] <= 4'd9 && weekday_bcd <= 3'd6
			&& second_bcd[3:0] <= 4'd9 && year_bcd[3:0] <= 4'd9)
		else $error("calendar fields out of range");

endmodule

bind epoch_to_bcd_calendar_core ecal_checker u_ecal_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (stamp.ready),
	.out_valid    (cal.valid),
	.out_ready    (cal.ready),
	.second_bcd   (cal.second_bcd),
	.minute_bcd   (cal.minute_bcd),
	.hour_bcd     (cal.hour_bcd),
	.weekday_bcd  (cal.weekday_bcd),
	.date_bcd     (cal.date_bcd),
	.month_bcd    (cal.month_bcd),
	.year_bcd     (cal.year_bcd),
	.out_of_range (cal.out_of_range)
);

// File: tb/calendar_checker.sv
// Checker that predicts the calendar fields of each timestamp and compares them with the block.
module calendar_checker (
	input  logic       clk,
	input  logic       arst_n,
	ecal_stamp_if      stamp,
	ecal_cal_if        cal,
	output int         errors,
	output int         pending
);

	// Calendar fields of one result transaction, in port order.
	typedef struct packed {
		logic [6:0] second_bcd;
		logic [6:0] minute_bcd;
		logic [5:0] hour_bcd;
		logic [2:0] weekday_bcd;
		logic [5:0] date_bcd;
		logic [4:0] month_bcd;
		logic [7:0] year_bcd;
		logic       out_of_range;
	} calendar_t;

	// First day of each month inside a four-year group; the first year is the leap one.
	localparam int unsigned MONTH_START [4][12] = '{
		'{   0,   31,   60,   91,  121,  152,  182,  213,  244,  274,  305,  335},
		'{ 366,  397,  425,  456,  486,  517,  547,  578,  609,  639,  670,  700},
		'{ 731,  762,  790,  821,  851,  882,  912,  943,  974, 1004, 1035, 1065},
		'{1096, 1127, 1155, 1186, 1216, 1247, 1277, 1308, 1339, 1369, 1400, 1430}
	};

	calendar_t calendar_q [$];

	// Two BCD digits of a value below one hundred.
	function automatic logic [7:0] two_digits(int unsigned v);
		return 8'(((v / 10) << 4) + (v % 10));
	endfunction

	// Full conversion of one timestamp into the clock register fields.
	function automatic calendar_t predict_calendar(logic [31:0] stamp_secs);
		calendar_t   r;
		int unsigned t;
		int unsigned sec;
		int unsigned mins;
		int unsigned hrs;
		int unsigned grp;
		int unsigned rem;
		int unsigned slot;
		int unsigned mon;
		int unsigned day;
		int unsigned yr;
		int unsigned y;
		int unsigned m;
		int unsigned d;
		int unsigned s;
		r = '0;
		t = stamp_secs;
		sec = t % 60;
		t = t / 60;
		mins = t % 60;
		t = t / 60;
		hrs = t % 24;
		t = t / 24;
		grp = t / 1461;
		rem = t % 1461;

		// Year slot first, then the month within that slot's row.
		slot = 0;
		for (int i = 3; i > 0; i--) begin
			if (rem >= MONTH_START[i][0]) begin
				slot = i;
				break;
			end
		end
		mon = 0;
		for (int i = 11; i > 0; i--) begin
			if (rem >= MONTH_START[slot][i]) begin
				mon = i;
				break;
			end
		end
		day = rem - MONTH_START[slot][mon] + 1;
		yr = grp * 4 + slot;

		// From 2100 on only the range flag is set.
		if (yr >= 100) begin
			r.out_of_range = 1'b1;
			return r;
		end

		// Weekday with the shifted-year rule, kept at full width.
		y = yr + 2000;
		m = mon + 1;
		d = day;
		if (m < 3) begin
			d = d + y;
			y = y - 1;
		end else begin
			d = d + y - 2;
		end
		s = (23 * m) / 9 + d + 4 + y / 4 - y / 100 + y / 400;

		r.second_bcd  = 7'(two_digits(sec));
		r.minute_bcd  = 7'(two_digits(mins));
		r.hour_bcd    = 6'(two_digits(hrs));
		r.weekday_bcd = 3'(s % 7);
		r.date_bcd    = 6'(two_digits(day));
		r.month_bcd   = 5'(two_digits(m));
		r.year_bcd    = two_digits(yr);
		return r;
	endfunction

	// Counts and prints a field mismatch.
	task automatic compare_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			$error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
		end
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	// Queue a prediction for each timestamp transaction and check each calendar transaction.
	always @(posedge clk) begin
		calendar_t want;
		if (arst_n) begin
			if (stamp.valid && stamp.ready) begin
				calendar_q.push_back(predict_calendar(stamp.seconds_since_2000));
			end
			if (cal.valid && cal.ready) begin
				if (calendar_q.size() == 0) begin
					errors++;
					$error("calendar transaction with no timestamp waiting");
				end else begin
					want = calendar_q.pop_front();
					compare_field("second_bcd", want.second_bcd, cal.second_bcd);
					compare_field("minute_bcd", want.minute_bcd, cal.minute_bcd);
					compare_field("hour_bcd", want.hour_bcd, cal.hour_bcd);
					compare_field("weekday_bcd", want.weekday_bcd, cal.weekday_bcd);
					compare_field("date_bcd", want.date_bcd, cal.date_bcd);
					compare_field("month_bcd", want.month_bcd, cal.month_bcd);
					compare_field("year_bcd", want.year_bcd, cal.year_bcd);
					compare_field("out_of_range", want.out_of_range, cal.out_of_range);
				end
			end
			pending = calendar_q.size();
		end
	end

endmodule

// File: tb/testbench.sv
// Top of the regression: clock, reset, timestamp stimulus, result back-pressure and verdict.
module testbench;

	// First second of 2100, where the range flag turns on.
	localparam logic [31:0] FIRST_BAD_SECOND = 32'd3155760000;
	localparam int unsigned DAY_SECONDS = 86400;
	// Cycles without any transaction before the run is declared hung.
	localparam int QUIET_LIMIT = 4000;
	// Random timestamps per idling phase.
	localparam int PHASE_ITEMS = 213;
	// Settle time after the last result, well past the five-stage pipeline.
	localparam int DRAIN_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors;
	int   pending;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;

	ecal_stamp_if stamp_ch ();
	ecal_cal_if   cal_ch ();

	epoch_to_bcd_calendar_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stamp  (stamp_ch),
		.cal    (cal_ch)
	);

	calendar_checker cal_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.stamp   (stamp_ch),
		.cal     (cal_ch),
		.errors  (errors),
		.pending (pending)
	);

	// Clock with a period of 12.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Result back-pressure, redrawn at every falling edge.
	always @(negedge clk) begin
		cal_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Hang detection: too long without a transaction on either channel.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((stamp_ch.valid && stamp_ch.ready) || (cal_ch.valid && cal_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("epoch_to_bcd_calendar_core regression: fail");
		$finish;
	end

	// Presents one timestamp, with random idle cycles first, and holds it until taken.
	task automatic send_stamp(logic [31:0] secs);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			stamp_ch.valid <= 1'b0;
			@(negedge clk);
		end
		stamp_ch.valid <= 1'b1;
		stamp_ch.seconds_since_2000 <= secs;
		@(posedge clk);
		while (!stamp_ch.ready) begin
			@(posedge clk);
		end
	endtask

	// Random timestamp: mostly inside the valid century, some near day edges,
	// some around the 2100 limit and some anywhere in 32 bits.
	function automatic logic [31:0] random_stamp();
		int unsigned days;
		int unsigned secs;
		case ($urandom_range(9))
			0, 1: begin
				return $urandom;
			end
			2, 3: begin
				days = $urandom_range(36524);
				secs = ($urandom_range(1) != 0) ? $urandom_range(86399, 86340) : $urandom_range(59);
				return days * DAY_SECONDS + secs;
			end
			4: begin
				return FIRST_BAD_SECOND - 32'd200000 + $urandom_range(400000);
			end
			default: begin
				return $urandom_range(FIRST_BAD_SECOND - 1, 0);
			end
		endcase
	endfunction

	// Reset, directed cases, then four idling phases of random timestamps.
	initial begin
		logic [31:0] directed [$];
		stamp_ch.valid = 1'b0;
		stamp_ch.seconds_since_2000 = '0;
		cal_ch.ready = 1'b0;
		directed = '{
			32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
			// Leap day of 2000, and the first of March after it.
			32'd59 * DAY_SECONDS, 32'd60 * DAY_SECONDS,
			// Last second of the leap year and first of the next year.
			32'd366 * DAY_SECONDS - 1, 32'd366 * DAY_SECONDS,
			// Last day of February in a common year.
			32'd425 * DAY_SECONDS - 1,
			// End of a four-year group and start of the next one.
			32'd1461 * DAY_SECONDS - 1, 32'd1461 * DAY_SECONDS,
			// Leap day of 2004.
			32'd1520 * DAY_SECONDS + 32'd43200,
			// Last valid second, first second of 2100, and the top of the range.
			FIRST_BAD_SECOND - 1, FIRST_BAD_SECOND, 32'hFFFFFFFF,
			32'h7FFFFFFF, 32'h80000000, 32'hAAAAAAAA, 32'h55555555
		};

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i]) begin
			send_stamp(directed[i]);
		end

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 58;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 58;
				end
				default: begin
					send_idle_pct = 26;
					recv_stall_pct = 26;
				end
			endcase
			repeat (PHASE_ITEMS) begin
				send_stamp(random_stamp());
			end
		end

		@(negedge clk);
		stamp_ch.valid <= 1'b0;
		recv_stall_pct = 0;

		// Wait for every predicted result, then let the pipeline settle.
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("epoch_to_bcd_calendar_core regression: pass");
		end else begin
			$display("epoch_to_bcd_calendar_core regression: fail");
		end
		$finish;
	end

endmodule
